>>> rtl/cwt_pkg.sv
package cwt_pkg;

  // One request item.
  typedef struct packed {
    logic        req_type;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] add_weight;
    logic [15:0] run_number;
  } req_t;

  // One result item.
  typedef struct packed {
    logic        hit;
    logic [31:0] weight_out;
    logic [15:0] first_run_out;
    logic [15:0] last_run_out;
    logic        table_full;
    logic [8:0]  entry_count_out;
  } rsp_t;

  // Request kinds.
  localparam logic REQ_OBSERVE = 1'b0;
  localparam logic REQ_LOOKUP  = 1'b1;

  // Width of the reported entry count.
  localparam int unsigned COUNT_OUT_W = 9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic take_hit;
    logic take_miss;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

>>> rtl/color_weight_table_core.sv
// Color weight table: keeps distinct 24-bit colors with an accumulated
// weight and the first and last run in which each was seen.
// Request channel (req_valid, req_stall, req): an item is taken at a clock
// edge where req_valid is high and req_stall is low. An observe item adds
// its weight to a matching entry or appends a new one if the table has room;
// a lookup item only reports. Result channel (rsp_valid, rsp_stall, rsp):
// exactly one item per request, in request order.
// Search: the filled entries are read one per cycle through the single
// registered memory read port, until a match is found or every filled entry
// has been read. The result then goes to the output register, and the
// controller returns to idle, where the next request is taken. One request
// is searched at a time. The result waits in the output register, and the
// next request is accepted while it waits; if the receiver still stalls
// when the next result is ready, the write of that result holds until the
// output register frees.
// Reset empties the table at once (the fill count returns to zero); no
// clearing pass is needed and the block accepts items right after reset.
module color_weight_table_core #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cwt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output cwt_pkg::rsp_t rsp
);

  cwt_pkg::cmd_t    cmd;
  cwt_pkg::status_t status;

  // Sequencer for accept, search and commit.
  cwt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Table memory, search compare and update arithmetic.
  cwt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

>>> rtl/cwt_ctrl.sv
module cwt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  cwt_pkg::status_t status,
  output cwt_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // New items are taken only while no search is running.
  assign req_stall = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.match) begin
          cmd.take_hit = 1'b1;
          state_next   = S_WRITE;
        end else if (status.scan_done) begin
          cmd.take_miss = 1'b1;
          state_next    = S_WRITE;
        end
      end
      S_WRITE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/cwt_datapath.sv
module cwt_datapath #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  cwt_pkg::req_t    req,
  input  cwt_pkg::cmd_t    cmd,
  output cwt_pkg::status_t status,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output cwt_pkg::rsp_t    rsp
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned OUT_W = cwt_pkg::COUNT_OUT_W;

  typedef struct packed {
    logic [23:0] key;
    logic [31:0] weight;
    logic [15:0] first_run;
    logic [15:0] last_run;
  } entry_t;

  entry_t mem [TABLE_ENTRIES];

  cwt_pkg::req_t   cur;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic             hit_r;
  logic [IDX_W-1:0] slot;
  entry_t           found;

  logic [23:0]      cur_key;
  logic             table_at_max;
  logic             observe;
  logic [32:0]      sum;
  entry_t           wr_entry;
  logic             do_write;
  logic [CNT_W-1:0] fill_count_next;
  logic [CNT_W+OUT_W-1:0] count_wide;
  cwt_pkg::rsp_t    rsp_next;

  assign cur_key      = {cur.red, cur.green, cur.blue};
  assign table_at_max = (fill_count == CNT_W'(TABLE_ENTRIES));
  assign observe      = (cur.req_type == cwt_pkg::REQ_OBSERVE);

  // Search status: a match on the entry read last cycle, or no entries left.
  assign status.match     = cmp_valid && (rd_data.key == cur_key);
  assign status.scan_done = !cmp_valid && (rd_addr >= fill_count);
  assign status.out_free  = !rsp_valid || !rsp_stall;

  // Updated entry: saturating weight and the larger last run on a hit, a new entry on a miss.
  assign sum = {1'b0, found.weight} + {17'b0, cur.add_weight};
  always_comb begin
    if (hit_r) begin
      wr_entry.key       = found.key;
      wr_entry.weight    = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      wr_entry.first_run = found.first_run;
      wr_entry.last_run  = (cur.run_number > found.last_run) ? cur.run_number
                                                             : found.last_run;
    end else begin
      wr_entry.key       = cur_key;
      wr_entry.weight    = {16'b0, cur.add_weight};
      wr_entry.first_run = cur.run_number;
      wr_entry.last_run  = cur.run_number;
    end
  end

  assign do_write        = cmd.commit && observe && (hit_r || !table_at_max);
  assign fill_count_next = (observe && !hit_r && !table_at_max) ? fill_count + 1'b1
                                                                : fill_count;
  assign count_wide      = {{OUT_W{1'b0}}, fill_count_next};

  // Result item assembled at commit time.
  always_comb begin
    rsp_next                 = '0;
    rsp_next.hit             = hit_r;
    rsp_next.entry_count_out = count_wide[OUT_W-1:0];
    if (hit_r) begin
      if (observe) begin
        rsp_next.weight_out    = wr_entry.weight;
        rsp_next.last_run_out  = wr_entry.last_run;
      end else begin
        rsp_next.weight_out    = found.weight;
        rsp_next.last_run_out  = found.last_run;
      end
      rsp_next.first_run_out = found.first_run;
    end else if (observe) begin
      if (table_at_max) begin
        rsp_next.table_full = 1'b1;
      end else begin
        rsp_next.weight_out    = wr_entry.weight;
        rsp_next.first_run_out = wr_entry.first_run;
        rsp_next.last_run_out  = wr_entry.last_run;
      end
    end
  end

  // Table memory: one registered read port, one write port.
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[slot] <= wr_entry;
    end
    rd_data <= mem[rd_addr[IDX_W-1:0]];
  end

  // Request capture, scan address and hit capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
    if (cmd.take_hit) begin
      slot  <= cmp_idx;
      found <= rd_data;
    end else if (cmd.take_miss) begin
      slot <= fill_count[IDX_W-1:0];
    end
    cmp_idx <= rd_addr[IDX_W-1:0];
    if (cmd.load) begin
      rd_addr <= '0;
    end else if (cmd.scan && (rd_addr < fill_count)) begin
      rd_addr <= rd_addr + 1'b1;
    end
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      cmp_valid  <= 1'b0;
      hit_r      <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan && (rd_addr < fill_count);
      if (cmd.take_hit) begin
        hit_r <= 1'b1;
      end else if (cmd.take_miss) begin
        hit_r <= 1'b0;
      end
      if (cmd.commit) begin
        fill_count <= fill_count_next;
        rsp_valid  <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
